// ----- rtl/pev_pkg.sv -----
package pev_pkg;

   localparam int unsigned STACK_DEPTH = 16;
   localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
   localparam int unsigned DEPTH_W = $clog2(STACK_DEPTH + 1);
   localparam int unsigned DATA_W = 64;
   localparam int unsigned HALF_W = DATA_W / 2;
   localparam int unsigned VALUE_W = 63;
   localparam int unsigned OP_W = 3;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned DIV_CNT_W = $clog2(DATA_W);
   localparam int unsigned IDX_W = $clog2(VALUE_W);

   typedef enum logic [OP_W-1:0] {
      OP_PUSH = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4,
      OP_MOD  = 3'd5,
      OP_POW  = 3'd6,
      OP_END  = 3'd7
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_UNDER   = 3'd1,
      ST_OVER    = 3'd2,
      ST_DIVZERO = 3'd3,
      ST_DEPTH   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      WD_PUSH,
      WD_ADD,
      WD_SUB,
      WD_QUO,
      WD_REM,
      WD_PROD,
      WD_ACC,
      WD_POWNEG
   } wdata_type;

   typedef enum logic [1:0] {
      MS_AB,
      MS_SQ,
      MS_ACC_A
   } mulsel_type;

   typedef enum logic {
      RD_TOP,
      RD_SECOND
   } rdsel_type;

   typedef struct packed {
      logic       take;
      rdsel_type  rd_sel;
      logic       b_load;
      logic       a_load;
      logic       wr_en;
      wdata_type  wr_sel;
      logic       err_set;
      status_type err_code;
      logic       rsp_load;
      logic       div_init;
      logic       div_step;
      logic       mul_load;
      mulsel_type mul_sel;
      logic       mul_step;
      logic       acc_init;
      logic       acc_load;
      logic       idx_dec;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   err_set;
      logic   depth_full;
      logic   depth_lt2;
      logic   b_zero;
      logic   b_neg;
      logic   mul_last;
      logic   div_last;
      logic   exp_bit;
      logic   idx_zero;
   } stat_type;

endpackage

// ----- rtl/pev_dpath.sv -----
module pev_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [pev_pkg::OP_W-1:0]          req_op,
   input  logic [pev_pkg::VALUE_W-1:0]       req_value,
   input  pev_pkg::cmd_type                  cmd,
   output pev_pkg::stat_type                 stat,
   output logic signed [pev_pkg::DATA_W-1:0] rsp_result,
   output logic [pev_pkg::STATUS_W-1:0]      rsp_status
);

   logic [pev_pkg::DATA_W-1:0] mem [pev_pkg::STACK_DEPTH];

   pev_pkg::op_type op_ff;
   logic [pev_pkg::VALUE_W-1:0] value_ff;
   logic [pev_pkg::DEPTH_W-1:0] depth_ff, depth_in;
   pev_pkg::status_type err_ff, err_in;
   logic [pev_pkg::DATA_W-1:0] rdata_ff, a_ff, b_ff;
   logic [pev_pkg::ADDR_W-1:0] raddr, waddr;
   logic [pev_pkg::DATA_W-1:0] wdata;

   logic [pev_pkg::DATA_W-1:0] rem_ff, quo_ff, ub_ff;
   logic [pev_pkg::DIV_CNT_W-1:0] dcnt_ff;
   logic [pev_pkg::DATA_W-1:0] dshift;
   logic [pev_pkg::DATA_W:0] ddiff;
   logic [pev_pkg::DATA_W-1:0] quo_fix, rem_fix;

   logic [pev_pkg::DATA_W-1:0] mx_ff, my_ff, pp_ff, prod_ff, acc_ff;
   logic [1:0] mcnt_ff;
   logic [pev_pkg::HALF_W-1:0] mul_x, mul_y;
   logic [pev_pkg::DATA_W-1:0] pp_in;
   logic [pev_pkg::IDX_W-1:0] idx_ff;
   logic [pev_pkg::DATA_W-1:0] pow_neg;

   pev_pkg::status_type end_status;

   always_comb begin
      unique case (cmd.rd_sel)
         pev_pkg::RD_TOP:    raddr = pev_pkg::ADDR_W'(depth_ff - 1'b1);
         pev_pkg::RD_SECOND: raddr = pev_pkg::ADDR_W'(depth_ff - 2'd2);
         default:            raddr = pev_pkg::ADDR_W'(depth_ff - 1'b1);
      endcase
   end

   assign dshift = {rem_ff[pev_pkg::DATA_W-2:0], quo_ff[pev_pkg::DATA_W-1]};
   assign ddiff = {1'b0, dshift} - {1'b0, ub_ff};
   assign quo_fix = (a_ff[pev_pkg::DATA_W-1] != b_ff[pev_pkg::DATA_W-1]) ? (0 - quo_ff) : quo_ff;
   assign rem_fix = a_ff[pev_pkg::DATA_W-1] ? (0 - rem_ff) : rem_ff;

   always_comb begin
      if (a_ff == pev_pkg::DATA_W'(1)) begin
         pow_neg = pev_pkg::DATA_W'(1);
      end else if (a_ff == {pev_pkg::DATA_W{1'b1}}) begin
         pow_neg = b_ff[0] ? {pev_pkg::DATA_W{1'b1}} : pev_pkg::DATA_W'(1);
      end else begin
         pow_neg = '0;
      end
   end

   always_comb begin
      unique case (cmd.wr_sel)
         pev_pkg::WD_PUSH:   wdata = {1'b0, value_ff};
         pev_pkg::WD_ADD:    wdata = a_ff + b_ff;
         pev_pkg::WD_SUB:    wdata = a_ff - b_ff;
         pev_pkg::WD_QUO:    wdata = quo_fix;
         pev_pkg::WD_REM:    wdata = rem_fix;
         pev_pkg::WD_PROD:   wdata = prod_ff;
         pev_pkg::WD_ACC:    wdata = acc_ff;
         pev_pkg::WD_POWNEG: wdata = pow_neg;
         default:            wdata = prod_ff;
      endcase
      waddr = (cmd.wr_sel == pev_pkg::WD_PUSH) ? depth_ff[pev_pkg::ADDR_W-1:0]
                                               : pev_pkg::ADDR_W'(depth_ff - 2'd2);
   end

   always_comb begin
      mul_x = (mcnt_ff == 2'd2) ? mx_ff[pev_pkg::DATA_W-1:pev_pkg::HALF_W]
                                : mx_ff[pev_pkg::HALF_W-1:0];
      mul_y = (mcnt_ff == 2'd1) ? my_ff[pev_pkg::DATA_W-1:pev_pkg::HALF_W]
                                : my_ff[pev_pkg::HALF_W-1:0];
      pp_in = pev_pkg::DATA_W'(mul_x) * pev_pkg::DATA_W'(mul_y);
   end

   always_comb begin
      if (err_ff != pev_pkg::ST_OK) begin
         end_status = err_ff;
      end else if (depth_ff == pev_pkg::DEPTH_W'(1)) begin
         end_status = pev_pkg::ST_OK;
      end else begin
         end_status = pev_pkg::ST_DEPTH;
      end
   end

   always_comb begin
      depth_in = depth_ff;
      err_in = err_ff;
      if (cmd.rsp_load) begin
         depth_in = '0;
         err_in = pev_pkg::ST_OK;
      end else if (cmd.err_set) begin
         err_in = cmd.err_code;
      end else if (cmd.wr_en) begin
         depth_in = (cmd.wr_sel == pev_pkg::WD_PUSH) ? depth_ff + 1'b1 : depth_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         err_ff <= pev_pkg::ST_OK;
      end else begin
         depth_ff <= depth_in;
         err_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
      if (cmd.wr_en) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff <= pev_pkg::op_type'(req_op);
         value_ff <= req_value;
      end
      if (cmd.b_load) begin
         b_ff <= rdata_ff;
      end
      if (cmd.a_load) begin
         a_ff <= rdata_ff;
      end
      if (cmd.rsp_load) begin
         rsp_result <= (depth_ff == '0) ? '0 : rdata_ff;
         rsp_status <= end_status;
      end
      if (cmd.div_init) begin
         ub_ff <= b_ff[pev_pkg::DATA_W-1] ? (0 - b_ff) : b_ff;
         quo_ff <= a_ff[pev_pkg::DATA_W-1] ? (0 - a_ff) : a_ff;
         rem_ff <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + 1'b1;
         quo_ff <= {quo_ff[pev_pkg::DATA_W-2:0], ~ddiff[pev_pkg::DATA_W]};
         rem_ff <= ddiff[pev_pkg::DATA_W] ? dshift : ddiff[pev_pkg::DATA_W-1:0];
      end
      if (cmd.mul_load) begin
         mcnt_ff <= '0;
         unique case (cmd.mul_sel)
            pev_pkg::MS_AB: begin
               mx_ff <= a_ff;
               my_ff <= b_ff;
            end
            pev_pkg::MS_SQ: begin
               mx_ff <= acc_ff;
               my_ff <= acc_ff;
            end
            default: begin
               mx_ff <= acc_ff;
               my_ff <= a_ff;
            end
         endcase
      end else if (cmd.mul_step) begin
         mcnt_ff <= mcnt_ff + 1'b1;
         pp_ff <= pp_in;
         unique case (mcnt_ff)
            2'd0:    prod_ff <= '0;
            2'd1:    prod_ff <= pp_ff;
            default: prod_ff <= prod_ff + {pp_ff[pev_pkg::HALF_W-1:0], {pev_pkg::HALF_W{1'b0}}};
         endcase
      end
      if (cmd.acc_init) begin
         acc_ff <= pev_pkg::DATA_W'(1);
         idx_ff <= pev_pkg::IDX_W'(pev_pkg::VALUE_W - 1);
      end else begin
         if (cmd.acc_load) begin
            acc_ff <= prod_ff;
         end
         if (cmd.idx_dec) begin
            idx_ff <= idx_ff - 1'b1;
         end
      end
   end

   always_comb begin
      stat.op = op_ff;
      stat.err_set = (err_ff != pev_pkg::ST_OK);
      stat.depth_full = (depth_ff >= pev_pkg::DEPTH_W'(pev_pkg::STACK_DEPTH));
      stat.depth_lt2 = (depth_ff < pev_pkg::DEPTH_W'(2));
      stat.b_zero = (b_ff == '0);
      stat.b_neg = b_ff[pev_pkg::DATA_W-1];
      stat.mul_last = (mcnt_ff == 2'd3);
      stat.div_last = (dcnt_ff == {pev_pkg::DIV_CNT_W{1'b1}});
      stat.exp_bit = b_ff[idx_ff];
      stat.idx_zero = (idx_ff == '0);
   end

endmodule

// ----- rtl/pev_ctrl.sv -----
module pev_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  pev_pkg::stat_type stat,
   output pev_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_FETCH_A,
      S_LOAD_A,
      S_EXEC,
      S_END_OUT,
      S_DIV_RUN,
      S_DIV_DONE,
      S_MUL_RUN,
      S_MUL_DONE,
      S_POW_SQ,
      S_POW_MB,
      S_POW_NEXT
   } state_type;

   typedef enum logic [1:0] {
      RET_MUL,
      RET_SQ,
      RET_MB
   } ret_type;

   state_type state_ff, state_in;
   ret_type ret_ff, ret_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd = '0;
      cmd.rd_sel = pev_pkg::RD_TOP;
      cmd.wr_sel = pev_pkg::WD_PUSH;
      cmd.err_code = pev_pkg::ST_OK;
      cmd.mul_sel = pev_pkg::MS_AB;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.op == pev_pkg::OP_END) begin
               state_in = S_END_OUT;
            end else if (stat.err_set) begin
               state_in = S_IDLE;
            end else if (stat.op == pev_pkg::OP_PUSH) begin
               if (stat.depth_full) begin
                  cmd.err_set = 1'b1;
                  cmd.err_code = pev_pkg::ST_OVER;
               end else begin
                  cmd.wr_en = 1'b1;
               end
               state_in = S_IDLE;
            end else if (stat.depth_lt2) begin
               cmd.err_set = 1'b1;
               cmd.err_code = pev_pkg::ST_UNDER;
               state_in = S_IDLE;
            end else begin
               state_in = S_FETCH_A;
            end
         end
         S_FETCH_A: begin
            cmd.b_load = 1'b1;
            cmd.rd_sel = pev_pkg::RD_SECOND;
            state_in = S_LOAD_A;
         end
         S_LOAD_A: begin
            cmd.a_load = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            unique case (stat.op)
               pev_pkg::OP_ADD, pev_pkg::OP_SUB: begin
                  cmd.wr_en = 1'b1;
                  cmd.wr_sel = (stat.op == pev_pkg::OP_ADD) ? pev_pkg::WD_ADD : pev_pkg::WD_SUB;
                  state_in = S_IDLE;
               end
               pev_pkg::OP_DIV, pev_pkg::OP_MOD: begin
                  if (stat.b_zero) begin
                     cmd.err_set = 1'b1;
                     cmd.err_code = pev_pkg::ST_DIVZERO;
                     state_in = S_IDLE;
                  end else begin
                     cmd.div_init = 1'b1;
                     state_in = S_DIV_RUN;
                  end
               end
               pev_pkg::OP_MUL: begin
                  cmd.mul_load = 1'b1;
                  cmd.mul_sel = pev_pkg::MS_AB;
                  ret_in = RET_MUL;
                  state_in = S_MUL_RUN;
               end
               default: begin
                  if (stat.b_neg) begin
                     cmd.wr_en = 1'b1;
                     cmd.wr_sel = pev_pkg::WD_POWNEG;
                     state_in = S_IDLE;
                  end else begin
                     cmd.acc_init = 1'b1;
                     state_in = S_POW_SQ;
                  end
               end
            endcase
         end
         S_END_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DIV_RUN: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_DIV_DONE;
            end
         end
         S_DIV_DONE: begin
            cmd.wr_en = 1'b1;
            cmd.wr_sel = (stat.op == pev_pkg::OP_DIV) ? pev_pkg::WD_QUO : pev_pkg::WD_REM;
            state_in = S_IDLE;
         end
         S_MUL_RUN: begin
            cmd.mul_step = 1'b1;
            if (stat.mul_last) begin
               state_in = S_MUL_DONE;
            end
         end
         S_MUL_DONE: begin
            unique case (ret_ff)
               RET_MUL: begin
                  cmd.wr_en = 1'b1;
                  cmd.wr_sel = pev_pkg::WD_PROD;
                  state_in = S_IDLE;
               end
               RET_SQ: begin
                  cmd.acc_load = 1'b1;
                  state_in = stat.exp_bit ? S_POW_MB : S_POW_NEXT;
               end
               default: begin
                  cmd.acc_load = 1'b1;
                  state_in = S_POW_NEXT;
               end
            endcase
         end
         S_POW_SQ: begin
            cmd.mul_load = 1'b1;
            cmd.mul_sel = pev_pkg::MS_SQ;
            ret_in = RET_SQ;
            state_in = S_MUL_RUN;
         end
         S_POW_MB: begin
            cmd.mul_load = 1'b1;
            cmd.mul_sel = pev_pkg::MS_ACC_A;
            ret_in = RET_MB;
            state_in = S_MUL_RUN;
         end
         S_POW_NEXT: begin
            if (stat.idx_zero) begin
               cmd.wr_en = 1'b1;
               cmd.wr_sel = pev_pkg::WD_ACC;
               state_in = S_IDLE;
            end else begin
               cmd.idx_dec = 1'b1;
               state_in = S_POW_SQ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff <= RET_MUL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/postfix_stack_evaluator_top.sv -----
// Channel   Handshake              Payload
// req       req_valid/req_ready    req_op[2:0], req_value[62:0]
// rsp       rsp_valid/rsp_ready    rsp_result[63:0] signed, rsp_status[2:0]
//
// Multiply runs through a shared 32x32 multiplier used over four steps.
// Divide and modulo use the one-bit-per-cycle restoring divider.
// Power squares, then multiplies by the base where the exponent bit is set, for each of 63 bits.
// Reset is synchronous; the stack holds no data worth keeping until written.
// A waiting result does not block the next item; only the next end item waits for it.
module postfix_stack_evaluator_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [pev_pkg::OP_W-1:0]          req_op,
   input  logic [pev_pkg::VALUE_W-1:0]       req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [pev_pkg::DATA_W-1:0] rsp_result,
   output logic [pev_pkg::STATUS_W-1:0]      rsp_status
);

   pev_pkg::cmd_type cmd;
   pev_pkg::stat_type stat;

   pev_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pev_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_op     (req_op),
      .req_value  (req_value),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_result (rsp_result),
      .rsp_status (rsp_status)
   );

endmodule

// ----- tb/pev_checker.sv -----
module pev_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [pev_pkg::OP_W-1:0]          req_op,
   input  logic [pev_pkg::VALUE_W-1:0]       req_value,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [pev_pkg::DATA_W-1:0] rsp_result,
   input  logic [pev_pkg::STATUS_W-1:0]      rsp_status,
   output int                                fail_count,
   output int                                pending_count,
   output int                                result_count
);

   typedef struct packed {
      logic [pev_pkg::DATA_W-1:0] result;
      pev_pkg::status_type        status;
   } answer_type;

   logic [pev_pkg::DATA_W-1:0] model_stack [pev_pkg::STACK_DEPTH];
   int unsigned                model_depth;
   pev_pkg::status_type        model_error;
   answer_type                 answers_due [$];

   function automatic logic [pev_pkg::DATA_W-1:0] signed_divide(
         logic [pev_pkg::DATA_W-1:0] a, logic [pev_pkg::DATA_W-1:0] b, bit want_rem);
      logic [pev_pkg::DATA_W-1:0] ua, ub, q, r;
      ua = a[pev_pkg::DATA_W-1] ? -a : a;
      ub = b[pev_pkg::DATA_W-1] ? -b : b;
      q = ua / ub;
      r = ua % ub;
      if (want_rem)
         return a[pev_pkg::DATA_W-1] ? -r : r;
      return (a[pev_pkg::DATA_W-1] != b[pev_pkg::DATA_W-1]) ? -q : q;
   endfunction

   function automatic logic [pev_pkg::DATA_W-1:0] integer_power(
         logic [pev_pkg::DATA_W-1:0] base, logic [pev_pkg::DATA_W-1:0] expo);
      logic [pev_pkg::DATA_W-1:0] acc;
      acc = 1;
      if (expo[pev_pkg::DATA_W-1]) begin
         if (base == 1)
            return 1;
         if (base == '1)
            return expo[0] ? '1 : 64'd1;
         return 0;
      end
      for (int i = pev_pkg::DATA_W - 2; i >= 0; i--) begin
         acc = acc * acc;
         if (expo[i])
            acc = acc * base;
      end
      return acc;
   endfunction

   task automatic evaluate_token(pev_pkg::op_type op, logic [pev_pkg::VALUE_W-1:0] value);
      logic [pev_pkg::DATA_W-1:0] a, b, r;
      answer_type ans;
      if (op == pev_pkg::OP_END) begin
         if (model_error != pev_pkg::ST_OK)
            ans.status = model_error;
         else
            ans.status = (model_depth == 1) ? pev_pkg::ST_OK : pev_pkg::ST_DEPTH;
         ans.result = (model_depth > 0) ? model_stack[model_depth-1] : '0;
         answers_due.push_back(ans);
         model_depth = 0;
         model_error = pev_pkg::ST_OK;
         return;
      end
      if (model_error != pev_pkg::ST_OK)
         return;
      if (op == pev_pkg::OP_PUSH) begin
         if (model_depth >= pev_pkg::STACK_DEPTH)
            model_error = pev_pkg::ST_OVER;
         else begin
            model_stack[model_depth] = {1'b0, value};
            model_depth++;
         end
         return;
      end
      if (model_depth < 2) begin
         model_error = pev_pkg::ST_UNDER;
         return;
      end
      b = model_stack[model_depth-1];
      a = model_stack[model_depth-2];
      case (op)
         pev_pkg::OP_ADD: r = a + b;
         pev_pkg::OP_SUB: r = a - b;
         pev_pkg::OP_MUL: r = a * b;
         pev_pkg::OP_DIV, pev_pkg::OP_MOD: begin
            if (b == 0) begin
               model_error = pev_pkg::ST_DIVZERO;
               return;
            end
            r = signed_divide(a, b, op == pev_pkg::OP_MOD);
         end
         default: r = integer_power(a, b);
      endcase
      model_depth--;
      model_stack[model_depth-1] = r;
   endtask

   task automatic report(string what, logic [pev_pkg::DATA_W-1:0] got,
                         logic [pev_pkg::DATA_W-1:0] want);
      $display("MISMATCH %0t: %s got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         model_depth = 0;
         model_error = pev_pkg::ST_OK;
         answers_due.delete();
         fail_count = 0;
         result_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (answers_due.size() == 0)
               report("unexpected result item", rsp_result, '0);
            else begin
               want = answers_due.pop_front();
               if (rsp_result !== want.result)
                  report("result", rsp_result, want.result);
               if (rsp_status !== want.status)
                  report("status", pev_pkg::DATA_W'(rsp_status),
                         pev_pkg::DATA_W'(want.status));
            end
         end
         if (req_valid && req_ready)
            evaluate_token(pev_pkg::op_type'(req_op), req_value);
      end
      pending_count = answers_due.size();
   end

endmodule

// ----- tb/tb.sv -----
module tb;

   logic                                clock = 0;
   logic                                reset = 1;
   logic                                req_valid = 0;
   logic                                req_ready;
   logic [pev_pkg::OP_W-1:0]            req_op = pev_pkg::OP_PUSH;
   logic [pev_pkg::VALUE_W-1:0]         req_value = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 0;
   logic signed [pev_pkg::DATA_W-1:0]   rsp_result;
   logic [pev_pkg::STATUS_W-1:0]        rsp_status;
   int                                  fail_count, pending_count, result_count;
   int                                  token_count = 0;
   bit                                  stimulus_done = 0;

   always #5 clock = ~clock;

   postfix_stack_evaluator_top u_top (.*);

   pev_checker u_checker (.*);

   task automatic send_token(pev_pkg::op_type op, logic [pev_pkg::VALUE_W-1:0] value);
      int gap;
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_op <= op;
      req_value <= value;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      token_count++;
      @(negedge clock);
   endtask

   function automatic logic [pev_pkg::VALUE_W-1:0] random_value();
      case ($urandom_range(0, 5))
         0: return pev_pkg::VALUE_W'($urandom_range(0, 3));
         1: return pev_pkg::VALUE_W'($urandom_range(0, 20));
         2: return '1;
         3: return pev_pkg::VALUE_W'({$urandom, $urandom});
         default: return pev_pkg::VALUE_W'($urandom_range(0, 1000));
      endcase
   endfunction

   task automatic send_expression();
      int depth, n;
      pev_pkg::op_type op;
      depth = 0;
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
         if (depth < 2 || ($urandom_range(0, 2) == 0 && depth < pev_pkg::STACK_DEPTH)) begin
            send_token(pev_pkg::OP_PUSH, random_value());
            depth++;
         end else begin
            op = pev_pkg::op_type'($urandom_range(pev_pkg::OP_ADD, pev_pkg::OP_POW));
            if (op == pev_pkg::OP_POW && $urandom_range(0, 3) != 0) begin
               send_token(pev_pkg::OP_PUSH, pev_pkg::VALUE_W'($urandom_range(0, 5)));
               send_token(pev_pkg::OP_POW, '0);
            end else begin
               send_token(op, random_value());
               depth--;
            end
         end
      end
      send_token(pev_pkg::OP_END, random_value());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // Directed expressions.
      send_token(pev_pkg::OP_END, '0);
      send_token(pev_pkg::OP_PUSH, '1);
      send_token(pev_pkg::OP_END, '0);
      send_token(pev_pkg::OP_PUSH, '1);
      send_token(pev_pkg::OP_PUSH, 1);
      send_token(pev_pkg::OP_ADD, '1);
      send_token(pev_pkg::OP_PUSH, 0);
      send_token(pev_pkg::OP_PUSH, 0);
      send_token(pev_pkg::OP_SUB, 0);
      send_token(pev_pkg::OP_MUL, 0);
      send_token(pev_pkg::OP_END, 0);
      send_token(pev_pkg::OP_PUSH, 7);
      send_token(pev_pkg::OP_PUSH, 0);
      send_token(pev_pkg::OP_DIV, 0);
      send_token(pev_pkg::OP_END, 0);
      send_token(pev_pkg::OP_PUSH, 0);
      send_token(pev_pkg::OP_PUSH, 7);
      send_token(pev_pkg::OP_PUSH, 2);
      send_token(pev_pkg::OP_SUB, 0);
      send_token(pev_pkg::OP_PUSH, 1);
      send_token(pev_pkg::OP_POW, 0);
      send_token(pev_pkg::OP_PUSH, 3);
      send_token(pev_pkg::OP_MOD, 0);
      send_token(pev_pkg::OP_ADD, 0);
      send_token(pev_pkg::OP_END, 0);
      for (int i = 0; i < 17; i++)
         send_token(pev_pkg::OP_PUSH, pev_pkg::VALUE_W'(i));
      send_token(pev_pkg::OP_END, 0);
      // Most negative value over minus one, and negative exponents.
      send_token(pev_pkg::OP_PUSH, 0);
      send_token(pev_pkg::OP_PUSH, '1);
      send_token(pev_pkg::OP_SUB, 0);
      send_token(pev_pkg::OP_PUSH, 1);
      send_token(pev_pkg::OP_SUB, 0);
      send_token(pev_pkg::OP_PUSH, 0);
      send_token(pev_pkg::OP_PUSH, 1);
      send_token(pev_pkg::OP_SUB, 0);
      send_token(pev_pkg::OP_DIV, 0);
      send_token(pev_pkg::OP_END, 0);
      for (int base = 0; base < 4; base++) begin
         send_token(pev_pkg::OP_PUSH, 0);
         send_token(pev_pkg::OP_PUSH, pev_pkg::VALUE_W'(base));
         send_token(pev_pkg::OP_SUB, 0);
         send_token(pev_pkg::OP_PUSH, 0);
         send_token(pev_pkg::OP_PUSH, 3);
         send_token(pev_pkg::OP_SUB, 0);
         send_token(pev_pkg::OP_POW, 0);
         send_token(pev_pkg::OP_END, 0);
      end
      send_token(pev_pkg::OP_MOD, 0);
      send_token(pev_pkg::OP_PUSH, 4);
      send_token(pev_pkg::OP_END, 0);
      while (token_count < 600) begin
         if ($urandom_range(0, 9) == 0)
            send_token(pev_pkg::op_type'($urandom_range(0, 7)),
                       pev_pkg::VALUE_W'({$urandom, $urandom}));
         else
            send_expression();
      end
      send_token(pev_pkg::OP_END, 0);
      req_valid <= 0;
      stimulus_done = 1;
   end

   initial begin
      int gap;
      forever begin
         @(negedge clock);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            rsp_ready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready))
            @(posedge clock);
      end
   end

   initial begin
      wait (stimulus_done);
      while (pending_count != 0)
         @(posedge clock);
      repeat (1500) @(posedge clock);
      $display("Sent %0d tokens and checked %0d results,", token_count, result_count);
      $display("covering every operator, error status and stack limit.");
      if (fail_count == 0 && pending_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #50000000;
      $display("simulation failed");
      $finish;
   end

endmodule
